[hdl/dq_pkg.sv]
// Shared types and constants for the circular double-ended queue.
package dq_pkg;

  localparam int unsigned WORD_W = 32;

  // All-ones word returned for missing values
  localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

  // Operation codes carried by each request
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Controller sequencing
  typedef enum logic {
    CS_IDLE  = 1'b0,
    CS_FETCH = 1'b1
  } ctrl_state_e;

  // One result, as handed from the controller to the output register
  typedef struct packed {
    status_e                   status;
    logic signed [WORD_W-1:0]  popped_value;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  rear_value;
    logic                      is_empty;
    logic                      is_full;
  } result_t;

endpackage

[hdl/dq_mem.sv]
// Entry store: one write port and one read port with registered read data.
module dq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AW-1:0]                    waddr_i,
  input  logic signed [dq_pkg::WORD_W-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AW-1:0]                    raddr_i,
  output logic signed [dq_pkg::WORD_W-1:0] rdata_o
);
  import dq_pkg::*;

  logic signed [WORD_W-1:0] mem_q [DEPTH];
  logic signed [WORD_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data valid in the cycle after the read enable
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dq_ctrl.sv]
// Deque controller: head/tail pointers, end-word cache and store sequencing.
module dq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value_i,
  input  logic                             out_free_i,
  output logic                             res_valid_o,
  output dq_pkg::result_t                  res_o,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output logic signed [dq_pkg::WORD_W-1:0] mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AW-1:0]                    mem_raddr_o,
  input  logic signed [dq_pkg::WORD_W-1:0] mem_rdata_i
);
  import dq_pkg::*;

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  ctrl_state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic empty_q, empty_d;
  logic signed [WORD_W-1:0] front_q, front_d, rear_q, rear_d;
  logic signed [WORD_W-1:0] popped_q, popped_d;
  logic fetch_front_q, fetch_front_d;

  op_e  op;
  logic accept;
  logic full_now;
  logic need_fetch;

  assign op         = op_e'(opcode_i);
  assign in_stall_o = (state_q == CS_FETCH) || !out_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full_now   = !empty_q && (idx_next(tail_q) == head_q);
  // A pop that leaves entries behind must read the new end word
  assign need_fetch = (op == OP_POP_FRONT || op == OP_POP_REAR) && !empty_q &&
                      (head_q != tail_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (accept && need_fetch) state_d = CS_FETCH;
      end
      CS_FETCH: begin
        if (out_free_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Datapath, store access and result
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    empty_d       = empty_q;
    front_d       = front_q;
    rear_d        = rear_q;
    popped_d      = popped_q;
    fetch_front_d = fetch_front_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = '0;
    mem_wdata_o   = push_value_i;
    mem_re_o      = 1'b0;
    mem_raddr_o   = '0;
    res_valid_o   = 1'b0;
    res_o.status       = STAT_DONE;
    res_o.popped_value = NEG_ONE;
    res_o.front_value  = NEG_ONE;
    res_o.rear_value   = NEG_ONE;
    res_o.is_empty     = empty_q;
    res_o.is_full      = 1'b0;

    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
              if (full_now) begin
                res_o.status = STAT_FULL;
              end else begin
                mem_we_o = 1'b1;
                empty_d  = 1'b0;
                if (empty_q) begin
                  head_d  = '0;
                  tail_d  = '0;
                  front_d = push_value_i;
                  rear_d  = push_value_i;
                  mem_waddr_o = '0;
                end else if (op == OP_PUSH_FRONT) begin
                  head_d      = idx_prev(head_q);
                  front_d     = push_value_i;
                  mem_waddr_o = head_d;
                end else begin
                  tail_d      = idx_next(tail_q);
                  rear_d      = push_value_i;
                  mem_waddr_o = tail_d;
                end
              end
            end
            default: begin
              // pops
              if (empty_q) begin
                res_o.status = STAT_EMPTY;
              end else begin
                popped_d = (op == OP_POP_FRONT) ? front_q : rear_q;
                fetch_front_d = (op == OP_POP_FRONT);
                if (head_q == tail_q) begin
                  empty_d = 1'b1;
                  head_d  = '0;
                  tail_d  = '0;
                end else if (op == OP_POP_FRONT) begin
                  head_d      = idx_next(head_q);
                  mem_re_o    = 1'b1;
                  mem_raddr_o = head_d;
                end else begin
                  tail_d      = idx_prev(tail_q);
                  mem_re_o    = 1'b1;
                  mem_raddr_o = tail_d;
                end
              end
            end
          endcase

          // Immediate result for everything but a fetching pop
          if (!need_fetch) begin
            res_valid_o = 1'b1;
            if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
              res_o.popped_value = empty_q ? NEG_ONE : popped_d;
            end
            res_o.is_empty    = empty_d;
            res_o.front_value = empty_d ? NEG_ONE : front_d;
            res_o.rear_value  = empty_d ? NEG_ONE : rear_d;
            res_o.is_full     = !empty_d && (idx_next(tail_d) == head_d);
          end
        end
      end
      CS_FETCH: begin
        if (out_free_i) begin
          if (fetch_front_q) front_d = mem_rdata_i;
          else               rear_d  = mem_rdata_i;
          res_valid_o        = 1'b1;
          res_o.popped_value = popped_q;
          res_o.front_value  = front_d;
          res_o.rear_value   = rear_d;
          res_o.is_empty     = 1'b0;
          res_o.is_full      = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  // End-word cache and pending pop
  always_ff @(posedge clk_i) begin
    front_q       <= front_d;
    rear_q        <= rear_d;
    popped_q      <= popped_d;
    fetch_front_q <= fetch_front_d;
  end

endmodule

[hdl/circular_double_ended_queue.sv]
// Top level of the circular double-ended queue with its output register.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+------------------------------------------
//   in      | in_valid_i/in_stall_o   | opcode_i, push_value_i
//   out     | out_valid_o/out_stall_i | status_o, popped_value_o, front_value_o,
//           |                         | rear_value_o, is_empty_o, is_full_o
//
// Pushes, refused requests and pops of the last entry give their result at once.
// A pop that leaves entries goes through the fetch state: the store's read port
// supplies the new end word in the cycle after the pointer moves.
// Reset empties the queue at once; the store needs no clearing.
// A stalled result holds in the output register; the next request is taken
// as soon as that register can be reloaded.
module circular_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       opcode_i,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic signed [dq_pkg::WORD_W-1:0] popped_value_o,
  output logic signed [dq_pkg::WORD_W-1:0] front_value_o,
  output logic signed [dq_pkg::WORD_W-1:0] rear_value_o,
  output logic                             is_empty_o,
  output logic                             is_full_o
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic                     out_valid_q;
  result_t                  res_q;
  result_t                  res;
  logic                     res_valid;
  logic                     out_free;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic signed [WORD_W-1:0] mem_wdata, mem_rdata;

  assign out_free = !out_valid_q || !out_stall_i;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  dq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = res_q.status;
  assign popped_value_o = res_q.popped_value;
  assign front_value_o  = res_q.front_value;
  assign rear_value_o   = res_q.rear_value;
  assign is_empty_o     = res_q.is_empty;
  assign is_full_o      = res_q.is_full;

endmodule

[tb/deque_checker.sv]
// Predictor and scoreboard for the circular double-ended queue.
`timescale 1ns / 1ps

module deque_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [1:0]                       opcode_i,
  input  logic signed [dq_pkg::WORD_W-1:0] push_value_i,
  // result channel
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [1:0]                       status_i,
  input  logic signed [dq_pkg::WORD_W-1:0] popped_value_i,
  input  logic signed [dq_pkg::WORD_W-1:0] front_value_i,
  input  logic signed [dq_pkg::WORD_W-1:0] rear_value_i,
  input  logic                             is_empty_i,
  input  logic                             is_full_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import dq_pkg::*;

  // Shadow copy of the deque
  logic signed [WORD_W-1:0] shadow_store [DEPTH];
  int unsigned              head_slot;
  int unsigned              tail_slot;
  bit                       shadow_empty;

  // Results predicted but not yet seen on the result channel
  result_t pending_results [$];

  function automatic int unsigned next_slot(int unsigned i);
    return (i >= DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int unsigned prev_slot(int unsigned i);
    return (i == 0) ? DEPTH - 1 : i - 1;
  endfunction

  function automatic bit shadow_full();
    return !shadow_empty && next_slot(tail_slot) == head_slot;
  endfunction

  // Apply one request to the shadow deque and build the result it gives
  function automatic result_t apply_deque_op(op_e op, logic signed [WORD_W-1:0] word);
    result_t res;
    res.status       = STAT_DONE;
    res.popped_value = NEG_ONE;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
      if (shadow_full()) begin
        res.status = STAT_FULL;
      end else begin
        if (shadow_empty) begin
          head_slot    = 0;
          tail_slot    = 0;
          shadow_empty = 1'b0;
        end else if (op == OP_PUSH_FRONT) begin
          head_slot = prev_slot(head_slot);
        end else begin
          tail_slot = next_slot(tail_slot);
        end
        shadow_store[(op == OP_PUSH_FRONT) ? head_slot : tail_slot] = word;
      end
    end else if (shadow_empty) begin
      res.status = STAT_EMPTY;
    end else begin
      res.popped_value = shadow_store[(op == OP_POP_FRONT) ? head_slot : tail_slot];
      if (head_slot == tail_slot) begin
        // last entry leaves: back to the reset pointers
        shadow_empty = 1'b1;
        head_slot    = 0;
        tail_slot    = 0;
      end else if (op == OP_POP_FRONT) begin
        head_slot = next_slot(head_slot);
      end else begin
        tail_slot = prev_slot(tail_slot);
      end
    end
    res.front_value = shadow_empty ? NEG_ONE : shadow_store[head_slot];
    res.rear_value  = shadow_empty ? NEG_ONE : shadow_store[tail_slot];
    res.is_empty    = shadow_empty;
    res.is_full     = shadow_full();
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] exp_v,
                                 logic [WORD_W-1:0] got_v);
    $display("%0t ns: %s mismatch, expected %h got %h", $time, what, exp_v, got_v);
    fail_count_o++;
  endtask

  // Watch both channels; results are checked before the new request is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      pending_results.delete();
      shadow_empty = 1'b1;
      head_slot    = 0;
      tail_slot    = 0;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", '0, status_i);
        end else begin
          exp_r = pending_results.pop_front();
          if (status_i !== exp_r.status)
            report_mismatch("status", exp_r.status, status_i);
          if (popped_value_i !== exp_r.popped_value)
            report_mismatch("popped_value", exp_r.popped_value, popped_value_i);
          if (front_value_i !== exp_r.front_value)
            report_mismatch("front_value", exp_r.front_value, front_value_i);
          if (rear_value_i !== exp_r.rear_value)
            report_mismatch("rear_value", exp_r.rear_value, rear_value_i);
          if (is_empty_i !== exp_r.is_empty)
            report_mismatch("is_empty", exp_r.is_empty, is_empty_i);
          if (is_full_i !== exp_r.is_full)
            report_mismatch("is_full", exp_r.is_full, is_full_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(apply_deque_op(op_e'(opcode_i), push_value_i));
      pending_o = pending_results.size();
    end
  end

endmodule

[tb/circular_double_ended_queue_tb.sv]
// Stimulus and verdict for the circular double-ended queue testbench.
`timescale 1ns / 1ps

module circular_double_ended_queue_tb;
  import dq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          PHASE_ITEMS = 260;
  localparam int          HOLD_CYCLES = 150;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               opcode_i = OP_POP_FRONT;
  logic signed [WORD_W-1:0] push_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [1:0]               status_o;
  logic signed [WORD_W-1:0] popped_value_o;
  logic signed [WORD_W-1:0] front_value_o;
  logic signed [WORD_W-1:0] rear_value_o;
  logic                     is_empty_o;
  logic                     is_full_o;

  int fail_count;
  int pending_count;

  // Idle and stall odds in percent; hold_off asks for one long receiver stall
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_off  = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  circular_double_ended_queue #(.DEPTH(DEPTH)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .front_value_o  (front_value_o),
    .rear_value_o   (rear_value_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

  deque_checker #(.DEPTH(DEPTH)) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .push_value_i   (push_value_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .popped_value_i (popped_value_o),
    .front_value_i  (front_value_o),
    .rear_value_i   (rear_value_o),
    .is_empty_i     (is_empty_o),
    .is_full_i      (is_full_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_count)
  );

  // Result side: random stall, or one long hold-off when asked
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(op_e op, logic signed [WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    push_value_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Mostly random words, with the extremes and -1 mixed in
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return {1'b1, {(WORD_W-1){1'b0}}};
      1:       return {1'b0, {(WORD_W-1){1'b1}}};
      2:       return NEG_ONE;
      3:       return '0;
      4:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // A phase of random requests; push bias swings so full and empty recur
  task automatic run_random(int count);
    int push_bias;
    bit is_push;
    bit at_front;
    push_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 85;
          1:       push_bias = 15;
          default: push_bias = 50;
        endcase
      end
      is_push  = ($urandom_range(99) < push_bias);
      at_front = 1'($urandom_range(1));
      if (is_push)
        send_request(at_front ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_word());
      else
        send_request(at_front ? OP_POP_FRONT : OP_POP_REAR, pick_word());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: refused pops, extremes, a fetching and a last-entry pop, fill with wrap, refused pushes
    send_request(OP_POP_FRONT, 32'h1234_5678);
    send_request(OP_POP_REAR, NEG_ONE);
    send_request(OP_PUSH_REAR, 32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 32'h8000_0000);
    send_request(OP_POP_FRONT, '0);
    send_request(OP_POP_REAR, '0);
    for (int k = 0; k < DEPTH; k++) begin
      case (k % 4)
        0:       send_request(OP_PUSH_FRONT, NEG_ONE);
        1:       send_request(OP_PUSH_REAR, 32'h5555_5555);
        2:       send_request(OP_PUSH_FRONT, 32'haaaa_aaaa);
        default: send_request(OP_PUSH_REAR, k);
      endcase
    end
    send_request(OP_PUSH_FRONT, 32'hdead_beef);
    send_request(OP_PUSH_REAR, 32'h0bad_f00d);

    // Random phases with different idle and stall mixes
    run_random(PHASE_ITEMS);
    idle_pct  = 70;
    run_random(PHASE_ITEMS);
    idle_pct  = 0;
    stall_pct = 70;
    run_random(PHASE_ITEMS);
    idle_pct  = 27;
    stall_pct = 27;
    run_random(PHASE_ITEMS);

    // Long receiver hold-off while requests keep coming
    idle_pct  = 0;
    stall_pct = 0;
    hold_off  = 1'b1;
    run_random(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    stall_pct = 0;
    wait (pending_count == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
hdl/dq_pkg.sv
hdl/dq_mem.sv
hdl/dq_ctrl.sv
hdl/circular_double_ended_queue.sv
tb/deque_checker.sv
tb/circular_double_ended_queue_tb.sv
